FILE: src/spa_pkg.sv
`timescale 1ns / 1ps

package spa_pkg;

    localparam int COEF_W = 16;
    localparam int EXP_W  = 16;
    localparam int SUM_W  = 17;

    // Item selector codes; the fourth code carries no meaning and is discarded.
    typedef enum logic [1:0]
    {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_RUN      = 2'd2
    } op_t;

    typedef struct packed
    {
        op_t               op;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  exp;
    } cmd_t;

    typedef struct packed
    {
        logic signed [SUM_W-1:0] coef;
        logic [EXP_W-1:0]        exp;
        logic                    last;
        logic                    empty_res;
        logic                    overflow;
    } res_t;

    typedef struct packed
    {
        logic busy;
        logic dropped;
    } back_stat_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_MERGE
    } back_state_t;

endpackage

FILE: src/spa_fifo.sv
`timescale 1ns / 1ps

module spa_fifo
    import spa_pkg::*;
#(
    parameter type DATA_T = logic [0:0],
    parameter int  DEPTH  = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  DATA_T wr_data,
    output logic  full,
    input  logic  rd_en,
    output DATA_T rd_data,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    DATA_T          slot [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  cnt_reg;
    logic [NW-1:0]  cnt_next;
    logic           do_wr;
    logic           do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/spa_front.sv
`timescale 1ns / 1ps

module spa_front
    import spa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        op,
    input  logic [COEF_W-1:0] term_coef,
    input  logic [EXP_W-1:0]  term_exp,
    input  logic              cmd_pop,
    output logic              cmd_valid,
    output cmd_t              cmd_data
);

    cmd_t cmd_in;
    logic cmd_keep;
    logic cmd_full;
    logic cmd_empty;

    // Items with a meaningless selector are taken and then discarded here.
    always_comb
    begin
        cmd_in.coef = term_coef;
        cmd_in.exp  = term_exp;
        cmd_in.op   = OP_RUN;
        cmd_keep    = 1'b0;
        case (op)
            OP_APPEND_A:
            begin
                cmd_in.op = OP_APPEND_A;
                cmd_keep  = 1'b1;
            end
            OP_APPEND_B:
            begin
                cmd_in.op = OP_APPEND_B;
                cmd_keep  = 1'b1;
            end
            OP_RUN:
            begin
                cmd_in.op = OP_RUN;
                cmd_keep  = 1'b1;
            end
            default:
            begin
                cmd_keep = 1'b0;
            end
        endcase
    end

    spa_fifo #(
        .DATA_T (cmd_t),
        .DEPTH  (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && cmd_keep),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_data),
        .empty   (cmd_empty)
    );

    assign full      = cmd_full;
    assign cmd_valid = !cmd_empty;

endmodule

FILE: src/spa_back.sv
`timescale 1ns / 1ps

module spa_back
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd_data,
    output logic       cmd_pop,
    input  logic       res_full,
    output logic       res_push,
    output res_t       res_data,
    output back_stat_t stat
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int WW = COEF_W + EXP_W;
    localparam logic [CW-1:0] CAP = CW'(MAX_TERMS);

    logic [WW-1:0] mem_a [MAX_TERMS];
    logic [WW-1:0] mem_b [MAX_TERMS];
    logic [WW-1:0] rd_a_reg;
    logic [WW-1:0] rd_b_reg;

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;
    logic [CW-1:0] count_a_reg;
    logic [CW-1:0] count_a_next;
    logic [CW-1:0] count_b_reg;
    logic [CW-1:0] count_b_next;
    logic          dropped_reg;
    logic          dropped_next;

    logic              wr_a;
    logic              wr_b;
    logic              a_ok;
    logic              b_ok;
    logic              take_a;
    logic              take_b;
    logic [CW-1:0]     i_adv;
    logic [CW-1:0]     j_adv;
    logic              is_last;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [EXP_W-1:0]  exp_a;
    logic [EXP_W-1:0]  exp_b;
    logic [SUM_W-1:0]  add_a;
    logic [SUM_W-1:0]  add_b;

    // During a merge, the read data registers hold the entries at the current heads.
    assign coef_a = rd_a_reg[WW-1:EXP_W];
    assign exp_a  = rd_a_reg[EXP_W-1:0];
    assign coef_b = rd_b_reg[WW-1:EXP_W];
    assign exp_b  = rd_b_reg[EXP_W-1:0];

    assign a_ok   = (i_reg < count_a_reg);
    assign b_ok   = (j_reg < count_b_reg);
    assign take_a = a_ok && (!b_ok || (exp_a >= exp_b));
    assign take_b = b_ok && (!a_ok || (exp_b >= exp_a));
    assign i_adv  = i_reg + CW'(take_a);
    assign j_adv  = j_reg + CW'(take_b);
    assign is_last = (i_adv >= count_a_reg) && (j_adv >= count_b_reg);

    assign add_a = take_a ? {coef_a[COEF_W-1], coef_a} : '0;
    assign add_b = take_b ? {coef_b[COEF_W-1], coef_b} : '0;

    always_comb
    begin
        res_data.coef      = add_a + add_b;
        res_data.exp       = take_a ? exp_a : (take_b ? exp_b : '0);
        res_data.last      = is_last;
        res_data.empty_res = !a_ok && !b_ok;
        res_data.overflow  = dropped_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        dropped_next = dropped_reg;
        wr_a         = 1'b0;
        wr_b         = 1'b0;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_data.op)
                        OP_APPEND_A:
                        begin
                            if (count_a_reg != CAP)
                            begin
                                wr_a         = 1'b1;
                                count_a_next = count_a_reg + CW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_APPEND_B:
                        begin
                            if (count_b_reg != CAP)
                            begin
                                wr_b         = 1'b1;
                                count_b_next = count_b_reg + CW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            state_next = ST_MERGE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (is_last)
                    begin
                        state_next   = ST_IDLE;
                        i_next       = '0;
                        j_next       = '0;
                        count_a_next = '0;
                        count_b_next = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_adv;
                        j_next = j_adv;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            count_a_reg <= '0;
            count_b_reg <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            dropped_reg <= dropped_next;
        end
    end

    // The read address follows the next head, so the registered data is ready in the next cycle.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[count_a_reg[AW-1:0]] <= {cmd_data.coef, cmd_data.exp};
        end
        if (wr_b)
        begin
            mem_b[count_b_reg[AW-1:0]] <= {cmd_data.coef, cmd_data.exp};
        end
        rd_a_reg <= mem_a[i_next[AW-1:0]];
        rd_b_reg <= mem_b[j_next[AW-1:0]];
    end

    assign stat.busy    = (state_reg == ST_MERGE);
    assign stat.dropped = dropped_reg;

endmodule

FILE: src/sparse_polynomial_adder.sv
`timescale 1ns / 1ps
// Channel   Transfer when      Ports
// input     push && !full      op, term_coef, term_exp
// result    pop && !empty      sum_coef, sum_exp, last, empty_res, overflow
//
// The merge engine takes load items at one per cycle while it is idle.
// A run item starts the single merge engine, which steps both heads and emits one
// merged term per cycle while the result queue has room (a zero term if empty).
// Reset (rst_n low) empties both term stores, the queues and the drop flag.
// Either side may stall: a two-entry command queue and a two-entry result queue
// decouple the input, the merge engine and the result side.

module sparse_polynomial_adder
    import spa_pkg::*;
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               op,
    input  logic signed [COEF_W-1:0] term_coef,
    input  logic [EXP_W-1:0]         term_exp,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [SUM_W-1:0]  sum_coef,
    output logic [EXP_W-1:0]         sum_exp,
    output logic                     last,
    output logic                     empty_res,
    output logic                     overflow
);

    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd_data;
    logic       res_push;
    logic       res_full;
    res_t       res_data;
    res_t       res_out;
    back_stat_t back_stat;

    spa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .term_coef (term_coef),
        .term_exp  (term_exp),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data)
    );

    spa_back #(
        .MAX_TERMS (MAX_TERMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .stat      (back_stat)
    );

    spa_fifo #(
        .DATA_T (res_t),
        .DEPTH  (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign sum_coef  = res_out.coef;
    assign sum_exp   = res_out.exp;
    assign last      = res_out.last;
    assign empty_res = res_out.empty_res;
    assign overflow  = res_out.overflow;

`ifndef ASSERT_OFF
    a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("merge engine wrote into a full result queue");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.empty_res) |->
            (res_data.last && (res_data.coef == '0) && (res_data.exp == '0)))
        else $error("empty result is not a single zero term");

    a_no_cmd_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.busy |-> !cmd_pop)
        else $error("command taken while a merge is in progress");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_full && res_data.last) |=>
            (!back_stat.busy && !back_stat.dropped))
        else $error("merge engine did not return to idle after the final term");
`endif

endmodule
